### sv/rle_pkg.sv
package rle_pkg;

   // default number of encoded bytes per output word
   localparam int OUT_LANES_DEF = 4;

   // one bank of the literal store, two banks in the RAM
   localparam int STORE_DEPTH = 128;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int ADDR_W      = IDX_W + 1;
   localparam int STORE_WORDS = 2 * STORE_DEPTH;

   // command queue between front and back
   localparam int CMD_DEPTH = 2;

   localparam logic [7:0] LIT_BASE = 8'd128;
   localparam logic [7:0] RUN_MAX  = 8'd128;

   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      CMD_PAIR,
      CMD_LIT,
      CMD_EMPTY
   } cmd_kind_type;

   // one unit of back-end work: a repeat pair, a literal flush or an empty end word
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   len;
      logic [7:0]   value;
      logic         bank;
      logic         is_end;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_done_type;

endpackage

### sv/rle_if.sv
interface rle_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, op, data_byte, input ready);
   modport sink (input valid, op, data_byte, output ready);
endinterface

interface rle_rsp_if #(
   parameter int OUT_LANES = rle_pkg::OUT_LANES_DEF
);
   logic                             valid;
   logic                             ready;
   logic [OUT_LANES*8-1:0]           lanes;
   logic [$clog2(OUT_LANES+1)-1:0]   byte_count;
   logic                             run_last;
   logic                             stream_end;

   modport source (output valid, lanes, byte_count, run_last, stream_end, input ready);
   modport sink (input valid, lanes, byte_count, run_last, stream_end, output ready);
endinterface

### sv/rle_ram.sv
module rle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/rle_front.sv
module rle_front (
   input  logic                   clock,
   input  logic                   reset,
   rle_req_if.sink                req_chan,
   input  logic                   q_full,
   output logic                   push_valid,
   output rle_pkg::cmd_type       push_cmd,
   output rle_pkg::ram_wr_type    ram_wr,
   input  rle_pkg::bank_done_type bank_done
);
   import rle_pkg::*;

   logic [7:0] len_ff, len_in;
   logic       rep_ff, rep_in;
   logic [7:0] last_ff, last_in;
   logic       bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in;
   logic       accept;
   logic       flip;

   // hold input while the queue is full or the bank being filled is still draining
   assign req_chan.ready = !q_full && !busy_ff[bank_ff];
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      len_in     = len_ff;
      rep_in     = rep_ff;
      last_in    = last_ff;
      flip       = 1'b0;
      push_valid = 1'b0;
      push_cmd   = '{kind: CMD_EMPTY, len: len_ff, value: last_ff, bank: bank_ff,
                     is_end: 1'b0};
      ram_wr     = '{en: 1'b0, addr: {bank_ff, len_ff[IDX_W-1:0]},
                     data: req_chan.data_byte};
      if (accept) begin
         if (req_chan.op == OP_END) begin
            push_valid      = 1'b1;
            push_cmd.is_end = 1'b1;
            if (rep_ff) begin
               push_cmd.kind = CMD_PAIR;
            end else if (len_ff != 8'd0) begin
               push_cmd.kind = CMD_LIT;
               flip          = 1'b1;
            end else begin
               push_cmd.kind = CMD_EMPTY;
            end
            len_in = 8'd0;
            rep_in = 1'b0;
         end else if (rep_ff) begin
            if (req_chan.data_byte != last_ff) begin
               // close the repeat run, open a literal run of one
               push_valid    = 1'b1;
               push_cmd.kind = CMD_PAIR;
               ram_wr.en     = 1'b1;
               ram_wr.addr   = {bank_ff, IDX_W'(0)};
               len_in        = 8'd1;
               rep_in        = 1'b0;
               last_in       = req_chan.data_byte;
            end else if (len_ff == RUN_MAX) begin
               push_valid    = 1'b1;
               push_cmd.kind = CMD_PAIR;
               len_in        = 8'd1;
            end else begin
               len_in = len_ff + 8'd1;
            end
         end else begin
            ram_wr.en = 1'b1;
            last_in   = req_chan.data_byte;
            if (len_ff != 8'd0 && req_chan.data_byte == last_ff) begin
               rep_in = 1'b1;
               len_in = 8'd2;
               if (len_ff >= 8'd2) begin
                  // flush the literals before the equal pair
                  push_valid    = 1'b1;
                  push_cmd.kind = CMD_LIT;
                  push_cmd.len  = len_ff - 8'd1;
                  flip          = 1'b1;
               end
            end else if (len_ff == 8'(STORE_DEPTH - 1)) begin
               push_valid    = 1'b1;
               push_cmd.kind = CMD_LIT;
               push_cmd.len  = len_ff + 8'd1;
               flip          = 1'b1;
               len_in        = 8'd0;
            end else begin
               len_in = len_ff + 8'd1;
            end
         end
      end
      bank_in = flip ? ~bank_ff : bank_ff;
      busy_in = busy_ff;
      if (bank_done.valid) begin
         busy_in[bank_done.bank] = 1'b0;
      end
      if (flip) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 8'd0;
         rep_ff  <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         len_ff  <= len_in;
         rep_ff  <= rep_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
      last_ff <= last_in;
   end
endmodule

### sv/rle_cmd_fifo.sv
module rle_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  rle_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output rle_pkg::cmd_type head,
   output logic             empty
);
   import rle_pkg::*;

   localparam int PTR_W  = $clog2(CMD_DEPTH);
   localparam int FILL_W = $clog2(CMD_DEPTH + 1);

   cmd_type           slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full    = fill_ff == FILL_W'(CMD_DEPTH);
   assign empty   = fill_ff == '0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

### sv/rle_back.sv
module rle_back #(
   parameter int OUT_LANES = rle_pkg::OUT_LANES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  rle_pkg::cmd_type            q_head,
   output logic                        pop,
   output logic [rle_pkg::ADDR_W-1:0]  rd_addr,
   input  logic [7:0]                  rd_data,
   output rle_pkg::bank_done_type      bank_done,
   rle_rsp_if.source                   rsp_chan
);
   import rle_pkg::*;

   localparam int CNT_W  = $clog2(OUT_LANES + 1);
   localparam int LANE_W = $clog2(OUT_LANES);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FIRST = 4'b0010,
      S_PAIR  = 4'b0100,
      S_BODY  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [LANE_W-1:0]      cnt_ff;
   logic [7:0]             asm_ff [OUT_LANES];
   logic                   rsp_valid_ff;
   logic [OUT_LANES*8-1:0] lanes_ff, lanes_next;
   logic [CNT_W-1:0]       count_ff;
   logic                   run_last_ff;
   logic                   stream_end_ff;

   logic       out_free;
   logic       bv, blast, empty_word;
   logic [7:0] bval;
   logic       send, step;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // byte source for the current command
   always_comb begin
      bv         = 1'b0;
      blast      = 1'b0;
      empty_word = 1'b0;
      bval       = cmd_ff.len;
      case (state_ff)
         S_FIRST: begin
            case (cmd_ff.kind)
               CMD_EMPTY: empty_word = 1'b1;
               CMD_LIT: begin
                  bv   = 1'b1;
                  bval = cmd_ff.len + LIT_BASE;
               end
               default: bv = 1'b1;
            endcase
         end
         S_PAIR: begin
            bv    = 1'b1;
            bval  = cmd_ff.value;
            blast = 1'b1;
         end
         S_BODY: begin
            bv    = 1'b1;
            bval  = rd_data;
            blast = {1'b0, idx_ff} == cmd_ff.len - 8'd1;
         end
         default: ;
      endcase
   end

   assign send = empty_word || (bv && (blast || cnt_ff == LANE_W'(OUT_LANES - 1)));
   assign step = (bv || empty_word) && (out_free || !send);

   always_comb begin
      for (int j = 0; j < OUT_LANES; j++) begin
         if (j < int'(cnt_ff)) begin
            lanes_next[j*8 +: 8] = asm_ff[j];
         end else if (j == int'(cnt_ff) && bv) begin
            lanes_next[j*8 +: 8] = bval;
         end else begin
            lanes_next[j*8 +: 8] = 8'd0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      pop       = 1'b0;
      bank_done = '{valid: 1'b0, bank: cmd_ff.bank};
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               cmd_in   = q_head;
               idx_in   = '0;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            if (step) begin
               case (cmd_ff.kind)
                  CMD_EMPTY: state_in = S_IDLE;
                  CMD_LIT:   state_in = S_BODY;
                  default:   state_in = S_PAIR;
               endcase
            end
         end
         S_PAIR: begin
            if (step) begin
               state_in = S_IDLE;
            end
         end
         S_BODY: begin
            if (step) begin
               if (blast) begin
                  state_in        = S_IDLE;
                  bank_done.valid = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // address from the next index so the registered read lines up with idx_ff
   assign rd_addr = {cmd_in.bank, idx_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (step && send) begin
            rsp_valid_ff <= 1'b1;
            cnt_ff       <= '0;
         end else begin
            if (rsp_chan.ready) begin
               rsp_valid_ff <= 1'b0;
            end
            if (step) begin
               cnt_ff <= cnt_ff + LANE_W'(1);
            end
         end
      end
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (step && send) begin
         lanes_ff      <= lanes_next;
         count_ff      <= empty_word ? '0 : CNT_W'(cnt_ff) + CNT_W'(1);
         run_last_ff   <= blast || empty_word;
         stream_end_ff <= (blast || empty_word) && cmd_ff.is_end;
      end else if (step) begin
         asm_ff[cnt_ff] <= bval;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.lanes      = lanes_ff;
   assign rsp_chan.byte_count = count_ff;
   assign rsp_chan.run_last   = run_last_ff;
   assign rsp_chan.stream_end = stream_end_ff;
endmodule

### sv/run_length_byte_encoder.sv
// Run-length byte encoder, byte-oriented repeat/literal code.
// req_chan carries one word per raw byte (op data) or an end-of-stream mark (op end).
// rsp_chan carries OUT_LANES encoded bytes per word, packed low lane first, with
// byte_count, run_last on the last word of each encoded run, stream_end on the
// last word of an end-of-stream flush.
// Flow: a request word that closes a run is classified combinationally and queued;
// the back end pops the command into its command register, then emits one encoded
// byte per cycle, limited by the single store read port, unless a finished output
// word is still held by a stalled receiver.
// Throughput: one request word per cycle while the two-deep command queue has room
// and the store bank being filled is not still being drained by a flush.
// Reset clears run state, bank ownership, the queue and the output register;
// the literal store is never read before it is written and needs no clearing.
// A stalled receiver holds the output word; the back end stops, the queue fills and
// req_chan.ready drops, with no word lost.
module run_length_byte_encoder #(
   parameter int OUT_LANES = rle_pkg::OUT_LANES_DEF
) (
   input logic       clock,
   input logic       reset,
   rle_req_if.sink   req_chan,
   rle_rsp_if.source rsp_chan
);
   import rle_pkg::*;

   // front to queue
   logic          q_full;
   logic          push_valid;
   cmd_type       push_cmd;

   // queue to back
   logic          q_empty;
   logic          pop;
   cmd_type       q_head;

   // literal store traffic: front writes one bank, back drains the other
   ram_wr_type    ram_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]    rd_data;
   bank_done_type bank_done;

   // classify bytes, track the open run, fill the store
   rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .ram_wr     (ram_wr),
      .bank_done  (bank_done)
   );

   // decouple classification from output packing
   rle_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // two banks of literal store in one RAM, bank select in the top address bit
   rle_ram #(
      .WIDTH (8),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // emit headers and bytes, pack them into output words
   rle_back #(
      .OUT_LANES (OUT_LANES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .bank_done (bank_done),
      .rsp_chan  (rsp_chan)
   );

   // the end mark always closes the words of its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.stream_end |-> rsp_chan.run_last)
      else $error("stream_end without run_last");

   // an empty word only reports an end with nothing pending
   a_empty_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.byte_count == '0 |-> rsp_chan.stream_end)
      else $error("empty output word outside end of stream");

   // never drop a command into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("command pushed into full queue");

   // the bank being handed back is never the one being written
   a_bank_handoff: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en && bank_done.valid |-> ram_wr.addr[ADDR_W-1] != bank_done.bank)
      else $error("store write into a bank still being drained");
endmodule
